### rtl/sdf_pkg.sv
// Package for the serial command deframer: command kinds, register
// indexes, reset values and the result record.
// Depends on nothing; the core, both checkers and the testbench import it.
package sdf_pkg;

    localparam int unsigned NUM_HEAD = 4;

    typedef enum logic [2:0] {
        KIND_MOTOR_ONE     = 3'd0,
        KIND_MOTOR_TWO     = 3'd1,
        KIND_LED_COLOR     = 3'd2,
        KIND_RELEASE_ONE   = 3'd3,
        KIND_RELEASE_TWO   = 3'd4,
        KIND_SHUTTER_OPEN  = 3'd5,
        KIND_SHUTTER_CLOSE = 3'd6,
        KIND_UNKNOWN       = 3'd7
    } t_cmd_kind;

    typedef enum logic [2:0] {
        CFG_PREAMBLE_ZEROS = 3'd0,
        CFG_MOTOR_ONE      = 3'd1,
        CFG_MOTOR_TWO      = 3'd2,
        CFG_LED_COLOR      = 3'd3,
        CFG_RELEASE_ONE    = 3'd4,
        CFG_RELEASE_TWO    = 3'd5,
        CFG_SHUTTER_OPEN   = 3'd6,
        CFG_SHUTTER_CLOSE  = 3'd7
    } t_cfg_idx;

    localparam logic [7:0] RST_PREAMBLE_ZEROS = 8'd5;
    localparam logic [7:0] RST_LED_LEVEL      = 8'd255;
    localparam logic [7:0] ZERO_RUN_MAX       = 8'd255;

    typedef struct packed {
        t_cmd_kind          cmd_kind;
        logic [7:0]         motor_delay;
        logic signed [15:0] motor_steps;
        logic [7:0]         red_level;
        logic [7:0]         green_level;
        logic [7:0]         blue_level;
        logic               shutter_level;
        logic [7:0]         frame_byte_count;
    } t_result;

endpackage

### rtl/sdf_rx_if.sv
// Handshake channel that carries one received serial byte per transfer.
// Depends on nothing.
interface sdf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/sdf_res_if.sv
// Handshake channel that carries one decoded command result per transfer.
// Depends on nothing.
interface sdf_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd_kind;
    logic [7:0]         motor_delay;
    logic signed [15:0] motor_steps;
    logic [7:0]         red_level;
    logic [7:0]         green_level;
    logic [7:0]         blue_level;
    logic               shutter_level;
    logic [7:0]         frame_byte_count;

    modport source (
        output valid, output cmd_kind, output motor_delay, output motor_steps,
        output red_level, output green_level, output blue_level,
        output shutter_level, output frame_byte_count, input ready
    );
    modport sink (
        input valid, input cmd_kind, input motor_delay, input motor_steps,
        input red_level, input green_level, input blue_level,
        input shutter_level, input frame_byte_count, output ready
    );
endinterface

### rtl/serial_command_deframer_core.sv
// Serial command deframer: one received byte per transfer, one result per frame.
// Latency: a result is valid in the cycle after the transfer of a frame's last byte.
// Throughput: one byte per cycle; stalls come only from a full result register whose
// result is not taken in the same cycle, and from reset until the input opens.
// Reset (synchronous, i_rst_n low): registers back to their defaults, LED levels
// 255, shutter closed, no frame open, result register empty.
// Depends on sdf_pkg, sdf_rx_if and sdf_res_if.
module serial_command_deframer_core
    import sdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdf_rx_if.sink      i_rx,
    sdf_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers: the preamble threshold and the seven command
    // codes, each read at its own fixed place.
    logic [7:0] r_cfg [8];

    // Framing state.
    logic [7:0] r_zero_run;
    logic       r_in_frame;
    logic [7:0] r_frame_length;
    logic [7:0] r_frame_index;
    logic [7:0] r_frame_head [NUM_HEAD];
    logic [7:0] r_byte_tally;

    // Levels kept between commands.
    logic [7:0] r_led_red;
    logic [7:0] r_led_green;
    logic [7:0] r_led_blue;
    logic       r_shutter;

    // Result register and the flag that opens the input after reset.
    t_result    r_res;
    logic       r_res_valid;
    logic       r_live;

    logic       accept;
    logic [7:0] d;
    logic [7:0] head_now [NUM_HEAD];
    logic [7:0] tally_inc;
    logic [7:0] index_inc;
    logic       frame_done;
    t_cmd_kind  kind;

    logic [7:0] n_zero_run;
    logic       n_in_frame;
    logic [7:0] n_frame_length;
    logic [7:0] n_frame_index;
    logic [7:0] n_byte_tally;
    logic [7:0] n_led_red;
    logic [7:0] n_led_green;
    logic [7:0] n_led_blue;
    logic       n_shutter;
    t_result    n_res;

    // Once the block is live after reset, the input is taken whenever the result
    // register is empty or is being emptied in this cycle, so a waiting result
    // never blocks a transfer that frees its slot.
    assign i_rx.ready = r_live && (!r_res_valid || o_res.ready);
    assign accept     = i_rx.valid && i_rx.ready;
    assign d          = i_rx.rx_byte;

    assign tally_inc  = r_byte_tally + 8'd1;
    assign index_inc  = r_frame_index + 8'd1;
    assign frame_done = r_in_frame && (index_inc == r_frame_length);

    // Frame head as it stands after this byte: the byte lands in its slot
    // when it is one of the first four frame bytes. Slots not written keep
    // whatever an earlier frame left there.
    always_comb begin
        for (int k = 0; k < NUM_HEAD; k++) begin
            if (r_in_frame && (r_frame_index == 8'(k))) begin
                head_now[k] = d;
            end else begin
                head_now[k] = r_frame_head[k];
            end
        end
    end

    // Command decode; when codes collide the lower register index wins.
    always_comb begin
        priority if (head_now[0] == r_cfg[CFG_MOTOR_ONE]) begin
            kind = KIND_MOTOR_ONE;
        end else if (head_now[0] == r_cfg[CFG_MOTOR_TWO]) begin
            kind = KIND_MOTOR_TWO;
        end else if (head_now[0] == r_cfg[CFG_LED_COLOR]) begin
            kind = KIND_LED_COLOR;
        end else if (head_now[0] == r_cfg[CFG_RELEASE_ONE]) begin
            kind = KIND_RELEASE_ONE;
        end else if (head_now[0] == r_cfg[CFG_RELEASE_TWO]) begin
            kind = KIND_RELEASE_TWO;
        end else if (head_now[0] == r_cfg[CFG_SHUTTER_OPEN]) begin
            kind = KIND_SHUTTER_OPEN;
        end else if (head_now[0] == r_cfg[CFG_SHUTTER_CLOSE]) begin
            kind = KIND_SHUTTER_CLOSE;
        end else begin
            kind = KIND_UNKNOWN;
        end
    end

    // Next state for one accepted byte.
    always_comb begin
        n_zero_run     = r_zero_run;
        n_in_frame     = r_in_frame;
        n_frame_length = r_frame_length;
        n_frame_index  = r_frame_index;
        n_byte_tally   = tally_inc;
        n_led_red      = r_led_red;
        n_led_green    = r_led_green;
        n_led_blue     = r_led_blue;
        n_shutter      = r_shutter;

        if (!r_in_frame) begin
            // Idle: zero bytes build up the preamble count, which saturates.
            // A nonzero byte below the threshold leaves the count alone.
            if (d == 8'd0) begin
                if (r_zero_run != ZERO_RUN_MAX) begin
                    n_zero_run = r_zero_run + 8'd1;
                end
            end else if (r_zero_run >= r_cfg[CFG_PREAMBLE_ZEROS]) begin
                n_frame_length = d;
                n_frame_index  = 8'd0;
                n_in_frame     = 1'b1;
            end
        end else if (frame_done) begin
            unique case (kind)
                KIND_LED_COLOR: begin
                    n_led_red   = head_now[1];
                    n_led_green = head_now[2];
                    n_led_blue  = head_now[3];
                end
                KIND_SHUTTER_OPEN:  n_shutter = 1'b1;
                KIND_SHUTTER_CLOSE: n_shutter = 1'b0;
                default: ;
            endcase
            n_byte_tally  = 8'd0;
            n_zero_run    = 8'd0;
            n_in_frame    = 1'b0;
            n_frame_index = 8'd0;
        end else begin
            n_frame_index = index_inc;
        end

        // Result record; the move fields read as zero for any other command.
        n_res.cmd_kind         = kind;
        n_res.motor_delay      = 8'd0;
        n_res.motor_steps      = 16'sd0;
        if (kind == KIND_MOTOR_ONE || kind == KIND_MOTOR_TWO) begin
            n_res.motor_delay = head_now[1];
            n_res.motor_steps = signed'({head_now[2], head_now[3]});
        end
        n_res.red_level        = n_led_red;
        n_res.green_level      = n_led_green;
        n_res.blue_level       = n_led_blue;
        n_res.shutter_level    = n_shutter;
        n_res.frame_byte_count = tally_inc;
    end

    // Configuration writes. The index covers exactly the eight registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_PREAMBLE_ZEROS] <= RST_PREAMBLE_ZEROS;
            r_cfg[CFG_MOTOR_ONE]      <= 8'd1;
            r_cfg[CFG_MOTOR_TWO]      <= 8'd2;
            r_cfg[CFG_LED_COLOR]      <= 8'd3;
            r_cfg[CFG_RELEASE_ONE]    <= 8'd4;
            r_cfg[CFG_RELEASE_TWO]    <= 8'd5;
            r_cfg[CFG_SHUTTER_OPEN]   <= 8'd6;
            r_cfg[CFG_SHUTTER_CLOSE]  <= 8'd7;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Framing and level state, updated once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live         <= 1'b0;
            r_zero_run     <= 8'd0;
            r_in_frame     <= 1'b0;
            r_frame_length <= 8'd0;
            r_frame_index  <= 8'd0;
            r_byte_tally   <= 8'd0;
            r_led_red      <= RST_LED_LEVEL;
            r_led_green    <= RST_LED_LEVEL;
            r_led_blue     <= RST_LED_LEVEL;
            r_shutter      <= 1'b0;
            for (int k = 0; k < NUM_HEAD; k++) begin
                r_frame_head[k] <= 8'd0;
            end
        end else begin
            r_live <= 1'b1;
            if (accept) begin
                r_zero_run     <= n_zero_run;
                r_in_frame     <= n_in_frame;
                r_frame_length <= n_frame_length;
                r_frame_index  <= n_frame_index;
                r_byte_tally   <= n_byte_tally;
                r_led_red      <= n_led_red;
                r_led_green    <= n_led_green;
                r_led_blue     <= n_led_blue;
                r_shutter      <= n_shutter;
                for (int k = 0; k < NUM_HEAD; k++) begin
                    r_frame_head[k] <= head_now[k];
                end
            end
        end
    end

    // Result register: filled when a frame completes, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept && frame_done) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && frame_done) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid            = r_res_valid;
    assign o_res.cmd_kind         = r_res.cmd_kind;
    assign o_res.motor_delay      = r_res.motor_delay;
    assign o_res.motor_steps      = r_res.motor_steps;
    assign o_res.red_level        = r_res.red_level;
    assign o_res.green_level      = r_res.green_level;
    assign o_res.blue_level       = r_res.blue_level;
    assign o_res.shutter_level    = r_res.shutter_level;
    assign o_res.frame_byte_count = r_res.frame_byte_count;

endmodule

### rtl/sdf_checker.sv
// Port-level checks for the serial command deframer, bound to its top level.
// Depends on sdf_pkg and on serial_command_deframer_core for the bind.
module sdf_checker
    import sdf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_rx_valid,
    input logic               i_rx_ready,
    input logic               i_res_valid,
    input logic               i_res_ready,
    input logic [2:0]         i_res_kind,
    input logic [7:0]         i_res_delay,
    input logic signed [15:0] i_res_steps
);

    // A result that is not taken stays, unchanged.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_kind) && $stable(i_res_delay)
            && $stable(i_res_steps))
        else $error("result changed while stalled");

    // A new result only appears after a byte transfer.
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("result without a byte transfer");

    // Only moves carry a delay and a step count.
    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_kind != KIND_MOTOR_ONE && i_res_kind != KIND_MOTOR_TWO
            |-> i_res_delay == 8'd0 && i_res_steps == 16'sd0)
        else $error("move fields set on a non-move command");

    // A full result register that is not drained blocks the input.
    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_rx_ready)
        else $error("byte taken while the result register is blocked");

endmodule

bind serial_command_deframer_core sdf_checker u_sdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.cmd_kind),
    .i_res_delay (o_res.motor_delay),
    .i_res_steps (o_res.motor_steps)
);

### tb/serial_command_deframer_checker.sv
`timescale 1ns / 100ps
// Checker for the serial command deframer: watches the byte, result and register
// write ports, predicts each decoded command and compares it with what the block returns.
// Depends on sdf_pkg, sdf_rx_if and sdf_res_if.
module serial_command_deframer_checker
    import sdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdf_rx_if          i_rx,
    sdf_res_if         i_res,
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending,
    output logic       o_frame_open
);

    logic [7:0] regs [8];
    logic [7:0] zero_run;
    logic       in_frame;
    logic [7:0] frame_len;
    logic [7:0] frame_idx;
    logic [7:0] head [NUM_HEAD];
    logic [7:0] tally;
    logic [7:0] red, green, blue;
    logic       shutter;
    t_result    decoded_q [$];
    int         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_frame_open = 1'b0;
    end

    task automatic reset_model();
        t_cfg_idx r;
        // Each command code register resets to its own index.
        r = r.first();
        do begin
            regs[r] = (r == CFG_PREAMBLE_ZEROS) ? RST_PREAMBLE_ZEROS : 8'(r);
            r = r.next();
        end while (r != r.first());
        zero_run  = '0;
        in_frame  = 1'b0;
        frame_len = '0;
        frame_idx = '0;
        foreach (head[k]) head[k] = '0;
        tally     = '0;
        red       = RST_LED_LEVEL;
        green     = RST_LED_LEVEL;
        blue      = RST_LED_LEVEL;
        shutter   = 1'b0;
        decoded_q.delete();
    endtask

    function automatic t_cmd_kind decode_kind(input logic [7:0] code);
        if (code == regs[CFG_MOTOR_ONE])     return KIND_MOTOR_ONE;
        if (code == regs[CFG_MOTOR_TWO])     return KIND_MOTOR_TWO;
        if (code == regs[CFG_LED_COLOR])     return KIND_LED_COLOR;
        if (code == regs[CFG_RELEASE_ONE])   return KIND_RELEASE_ONE;
        if (code == regs[CFG_RELEASE_TWO])   return KIND_RELEASE_TWO;
        if (code == regs[CFG_SHUTTER_OPEN])  return KIND_SHUTTER_OPEN;
        if (code == regs[CFG_SHUTTER_CLOSE]) return KIND_SHUTTER_CLOSE;
        return KIND_UNKNOWN;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_result cmd;
        tally = tally + 8'd1;
        if (!in_frame) begin
            if (b == 8'd0) begin
                if (zero_run != ZERO_RUN_MAX) zero_run = zero_run + 8'd1;
            end else if (zero_run >= regs[CFG_PREAMBLE_ZEROS]) begin
                frame_len = b;
                frame_idx = '0;
                in_frame  = 1'b1;
            end
        end else begin
            if (frame_idx < NUM_HEAD) head[frame_idx[1:0]] = b;
            frame_idx = frame_idx + 8'd1;
            if (frame_idx == frame_len) begin
                cmd = '0;
                cmd.cmd_kind = decode_kind(head[0]);
                case (cmd.cmd_kind)
                    KIND_MOTOR_ONE, KIND_MOTOR_TWO: begin
                        cmd.motor_delay = head[1];
                        cmd.motor_steps = {head[2], head[3]};
                    end
                    KIND_LED_COLOR: begin
                        red   = head[1];
                        green = head[2];
                        blue  = head[3];
                    end
                    KIND_SHUTTER_OPEN:  shutter = 1'b1;
                    KIND_SHUTTER_CLOSE: shutter = 1'b0;
                    default: ;
                endcase
                cmd.red_level        = red;
                cmd.green_level      = green;
                cmd.blue_level       = blue;
                cmd.shutter_level    = shutter;
                cmd.frame_byte_count = tally;
                decoded_q.push_back(cmd);
                tally     = '0;
                zero_run  = '0;
                in_frame  = 1'b0;
                frame_idx = '0;
            end
        end
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (decoded_q.size() == 0) begin
            $error("result transfer with no command pending");
            mismatches++;
        end else begin
            want = decoded_q.pop_front();
            check_field("cmd_kind", want.cmd_kind, i_res.cmd_kind);
            check_field("motor_delay", want.motor_delay, i_res.motor_delay);
            check_field("motor_steps", want.motor_steps, i_res.motor_steps);
            check_field("red_level", want.red_level, i_res.red_level);
            check_field("green_level", want.green_level, i_res.green_level);
            check_field("blue_level", want.blue_level, i_res.blue_level);
            check_field("shutter_level", want.shutter_level, i_res.shutter_level);
            check_field("frame_byte_count", want.frame_byte_count,
                        i_res.frame_byte_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_res.valid && i_res.ready) compare_result();
            if (i_cfg_we) regs[i_cfg_idx] = i_cfg_data;
            if (i_rx.valid && i_rx.ready) deframe_byte(i_rx.rx_byte);
        end
        o_pending    <= decoded_q.size();
        o_frame_open <= in_frame;
        o_fail_count <= mismatches;
    end

endmodule

### tb/serial_command_deframer_core_tb.sv
`timescale 1ns / 100ps
// Top of the serial command deframer testbench: clock, reset, register writes,
// byte stimulus with random gaps, random result stalls and the final verdict.
// Depends on sdf_pkg, sdf_rx_if, sdf_res_if, the block and serial_command_deframer_checker.
module serial_command_deframer_core_tb;
    import sdf_pkg::*;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    t_cfg_idx   i_cfg_idx  = CFG_PREAMBLE_ZEROS;
    logic [7:0] i_cfg_data = 8'd0;

    int         fail_count;
    int         pending;
    logic       frame_open;

    // Shadow of the register file, so that frames can be built from the live codes.
    logic [7:0] shadow [8];
    // When set, neither side idles: the block sees back-to-back transfers.
    bit         steady = 1'b0;
    // Every byte transferred into the block so far.
    int         sent_items = 0;

    sdf_rx_if  rx_ch ();
    sdf_res_if res_ch ();

    serial_command_deframer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    serial_command_deframer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (rx_ch),
        .i_res        (res_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frame_open (frame_open)
    );

    always #5 i_clk = ~i_clk;

    // Result side: before every transfer the receiver may hold ready low, unless
    // steady is set. Ready is only touched once per clock edge.
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // Offers one byte after a random gap and returns in the time step of its
    // transfer, with valid still high so that the next byte can follow directly.
    task automatic push_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!rx_ch.ready);
        sent_items++;
    endtask

    // A run of zeros, a length byte and the frame body. The body may be cut
    // short of the length, which leaves the frame open to swallow what follows.
    // Body bytes past the command, delay and step bytes are random.
    task automatic send_frame(input int zeros, input logic [7:0] len, input int body,
                              input logic [7:0] cmd, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        repeat (zeros) push_byte(8'd0);
        push_byte(len);
        for (int k = 0; k < body; k++) begin
            case (k)
                0:       push_byte(cmd);
                1:       push_byte(b1);
                2:       push_byte(b2);
                3:       push_byte(b3);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // The sender stops and waits for every predicted command to come back.
    task automatic hold_until_drained();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Brings the block to rest before a register write: any frame still open
    // is filled with random bytes and every result is collected.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (frame_open) begin
            push_byte(8'($urandom_range(0, 255)));
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the whole register file from the shadow on consecutive edges.
    task automatic write_regs();
        t_cfg_idx r;
        r = r.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= shadow[r];
            @(posedge i_clk);
            r = r.next();
        end while (r != r.first());
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_code();
        return shadow[t_cfg_idx'($urandom_range(CFG_MOTOR_ONE, CFG_SHUTTER_CLOSE))];
    endfunction

    // Picks a fresh register setting for a random phase. Phase zero runs at the
    // lowest threshold, phase one puts both extreme values into the code set,
    // and some phases duplicate a code so that the priority order matters.
    task automatic new_phase(input int phase);
        t_cfg_idx r;
        t_cfg_idx a;
        t_cfg_idx b;
        settle();
        r = r.first();
        do begin
            shadow[r] = 8'($urandom_range(0, 255));
            r = r.next();
        end while (r != r.first());
        shadow[CFG_PREAMBLE_ZEROS] = (phase == 0) ? 8'd1 : 8'($urandom_range(1, 8));
        if (phase == 1) begin
            shadow[CFG_MOTOR_ONE]     = 8'h00;
            shadow[CFG_SHUTTER_CLOSE] = 8'hFF;
        end
        if ($urandom_range(0, 2) == 0) begin
            a = t_cfg_idx'($urandom_range(CFG_MOTOR_ONE, CFG_SHUTTER_CLOSE));
            b = t_cfg_idx'($urandom_range(CFG_MOTOR_ONE, CFG_SHUTTER_CLOSE));
            shadow[a] = shadow[b];
        end
        write_regs();
        steady = ($urandom_range(0, 3) == 0);
    endtask

    // One random frame. Most are well formed with a known command code; some
    // carry idle noise ahead of them, a preamble that is too short, an unknown
    // command or a body cut short.
    task automatic random_frame();
        int          thr;
        int          zeros;
        int          body;
        int          pick;
        logic [7:0]  len;
        logic [7:0]  cmd;
        thr = int'(shadow[CFG_PREAMBLE_ZEROS]);
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 9) == 0) zeros = $urandom_range(0, thr - 1);
        else zeros = thr + $urandom_range(0, 2);
        pick = $urandom_range(0, 19);
        if (pick < 12)      len = 8'($urandom_range(1, 4));
        else if (pick < 18) len = 8'($urandom_range(5, 8));
        else                len = 8'($urandom_range(9, 24));
        body = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len - 1) : int'(len);
        cmd = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : pick_code();
        send_frame(zeros, len, body, cmd, 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 24) == 0) hold_until_drained();
    endtask

    initial begin
        t_cfg_idx r;
        int       phase;
        int       phase_mark;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'd0;
        // Shadow of the reset values: each code register holds its own index.
        r = r.first();
        do begin
            shadow[r] = (r == CFG_PREAMBLE_ZEROS) ? RST_PREAMBLE_ZEROS : 8'(r);
            r = r.next();
        end while (r != r.first());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: a nonzero byte inside the zero run must not clear the
        // count, and a motor move carries the largest delay and the most
        // negative step count.
        push_byte(8'd0);
        push_byte(8'd0);
        push_byte(8'h09);
        push_byte(8'd0);
        push_byte(8'd0);
        push_byte(8'd0);
        send_frame(0, 8'd4, 4, shadow[CFG_MOTOR_ONE], 8'hFF, 8'h80, 8'h00);

        // Lowest threshold, default codes: every command once. The short motor
        // move reuses the stale step bytes left by the LED frame, and the long
        // shutter frame drops its bytes past the fourth.
        settle();
        shadow[CFG_PREAMBLE_ZEROS] = 8'd1;
        write_regs();
        send_frame(1, 8'd4, 4, shadow[CFG_MOTOR_TWO], 8'h00, 8'h7F, 8'hFF);
        send_frame(1, 8'd4, 4, shadow[CFG_LED_COLOR], 8'h00, 8'h80, 8'hFF);
        send_frame(1, 8'd1, 1, shadow[CFG_SHUTTER_OPEN], 8'h00, 8'h00, 8'h00);
        send_frame(1, 8'd2, 2, shadow[CFG_MOTOR_ONE], 8'h5A, 8'h00, 8'h00);
        send_frame(1, 8'd1, 1, shadow[CFG_RELEASE_ONE], 8'h00, 8'h00, 8'h00);
        send_frame(1, 8'd1, 1, shadow[CFG_RELEASE_TWO], 8'h00, 8'h00, 8'h00);
        send_frame(1, 8'd7, 7, shadow[CFG_SHUTTER_CLOSE], 8'h01, 8'h02, 8'h03);
        send_frame(1, 8'd1, 1, 8'hC8, 8'h00, 8'h00, 8'h00);

        // Highest threshold with every code equal, so the first motor wins.
        // A run one short of the threshold must not open a frame, and the
        // zeros after it push the counter past its top: the next frame opens
        // only if the count holds there instead of wrapping. The byte count
        // of that frame, by contrast, wraps.
        settle();
        r = r.first();
        do begin
            shadow[r] = 8'hA5;
            r = r.next();
        end while (r != r.first());
        shadow[CFG_PREAMBLE_ZEROS] = 8'hFF;
        write_regs();
        send_frame(254, 8'd6, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_frame(50, 8'd6, 6, 8'hA5, 8'h10, 8'h20, 8'h30);

        // Random phases, each with its own register setting.
        phase      = 0;
        phase_mark = sent_items;
        while (sent_items < 600) begin
            if (sent_items >= phase_mark) begin
                new_phase(phase);
                phase++;
                phase_mark += 60;
            end
            random_frame();
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
